/* rtl/dsi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dsi_pkg;

  localparam int LANES   = 256;
  localparam int STAGES  = 10;
  localparam int SPAN    = STAGES * (LANES - 1) + 1;  // slots per lane row
  localparam int DEPTH   = LANES * SPAN;              // history bytes
  localparam int LANE_W  = $clog2(LANES);
  localparam int SLOT_W  = $clog2(SPAN);
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int SYM_W   = 8;
  localparam int NCELL   = 6;                         // pipeline cells

  localparam logic KIND_SYMBOL = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;
  localparam logic DIR_FWD     = 1'b0;
  localparam logic DIR_REV     = 1'b1;

  // One beat as it moves down the cell chain; fields fill in stage by stage.
  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic              last;
    logic              dir;
    logic [SLOT_W-1:0] fill;     // whole vectors seen since flush, saturating
    logic [SLOT_W-1:0] vc;       // write slot of this vector
    logic [SLOT_W-1:0] dfwd;     // STAGES * lane
    logic [SLOT_W-1:0] dly;      // delay in vectors for this lane
    logic [SLOT_W-1:0] slot;     // read slot
    logic              hit;      // read slot holds data written since flush
    logic              pass;     // zero delay, symbol goes straight through
    logic [ADDR_W-1:0] base;     // row base address of this lane
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
  } beat_t;

endpackage

`default_nettype wire

/* rtl/dsi_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module dsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/dsi_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module dsi_cell import dsi_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  up_valid_i,
  output logic       up_ready_o,
  input  wire beat_t up_beat_i,
  output logic       dn_valid_o,
  input  wire logic  dn_ready_i,
  output beat_t      dn_beat_o
);

  logic  valid_q, valid_d;
  beat_t beat_q;

  // Takes a beat when empty or when the current one leaves this cycle.
  assign up_ready_o = !valid_q || dn_ready_i;
  assign valid_d    = up_ready_o ? up_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      beat_q <= up_beat_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_beat_o  = beat_q;

endmodule

`default_nettype wire

/* rtl/diagonal_symbol_interleaver.sv */
`timescale 1ns / 1ps
`default_nettype none

// A symbol beat passes through all six cells, each a register, to the output.
// Throughput: one beat per cycle while stall_i is low; the chain of six
//   cells and the single write / single read history RAM sustain that with
//   no stall of their own. Flush beats give no result.
// Reset clears the counters, the fill count and direction. The history RAM is
//   not swept: the fill count marks stale slots, which read as zero.
module diagonal_symbol_interleaver import dsi_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input beats
  input  wire logic             valid_i,
  output logic                  stall_o,
  input  wire logic             kind_i,
  input  wire logic [SYM_W-1:0] symbol_i,
  // output beats
  output logic                  valid_o,
  input  wire logic             stall_i,
  output logic      [SYM_W-1:0] symbol_out_o,
  output logic                  last_of_vector_o,
  // direction register write
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Direction reg: to be written only while the block is idle; not enforced.
  // ---------------------------------------------------------------------------
  logic dir_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_FWD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dir_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain wiring
  // ---------------------------------------------------------------------------
  logic  up_valid [NCELL];
  logic  up_ready [NCELL];
  beat_t up_beat  [NCELL];
  logic  dn_valid [NCELL];
  logic  dn_ready [NCELL];
  beat_t dn_beat  [NCELL];

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    dsi_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (up_valid[k]),
      .up_ready_o (up_ready[k]),
      .up_beat_i  (up_beat[k]),
      .dn_valid_o (dn_valid[k]),
      .dn_ready_i (dn_ready[k]),
      .dn_beat_o  (dn_beat[k])
    );
    if (k < NCELL - 1) begin : g_link
      assign up_valid[k+1] = dn_valid[k];
      assign dn_ready[k]   = up_ready[k+1];
    end
  end

  assign dn_ready[NCELL-1] = !stall_i;

  // ---------------------------------------------------------------------------
  // Front end: lane / vector counters. Row base and forward delay are stepped
  // along with the lane so no multiply is needed.
  // ---------------------------------------------------------------------------
  logic              in_acc;
  logic              lane_end;
  logic [LANE_W-1:0] lane_q, lane_d;
  logic [SLOT_W-1:0] vc_q, vc_d;
  logic [SLOT_W-1:0] fill_q, fill_d;
  logic [SLOT_W-1:0] dfwd_q, dfwd_d;
  logic [ADDR_W-1:0] base_q, base_d;

  assign stall_o  = !up_ready[0];
  assign in_acc   = valid_i && !stall_o;
  assign lane_end = (lane_q == LANE_W'(LANES - 1));

  always_comb begin
    lane_d = lane_q;
    vc_d   = vc_q;
    fill_d = fill_q;
    dfwd_d = dfwd_q;
    base_d = base_q;
    if (in_acc) begin
      if (kind_i == KIND_FLUSH) begin
        lane_d = '0;
        vc_d   = '0;
        fill_d = '0;
        dfwd_d = '0;
        base_d = '0;
      end else if (lane_end) begin
        lane_d = '0;
        dfwd_d = '0;
        base_d = '0;
        vc_d   = (vc_q == SLOT_W'(SPAN - 1)) ? '0 : vc_q + 1'b1;
        fill_d = (fill_q == SLOT_W'(SPAN - 1)) ? fill_q : fill_q + 1'b1;
      end else begin
        lane_d = lane_q + 1'b1;
        dfwd_d = dfwd_q + SLOT_W'(STAGES);
        base_d = base_q + ADDR_W'(SPAN);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
      vc_q   <= '0;
      fill_q <= '0;
      dfwd_q <= '0;
      base_q <= '0;
    end else begin
      lane_q <= lane_d;
      vc_q   <= vc_d;
      fill_q <= fill_d;
      dfwd_q <= dfwd_d;
      base_q <= base_d;
    end
  end

  // Cell 0 takes symbol beats only; a flush just resets the counters.
  assign up_valid[0] = valid_i && (kind_i == KIND_SYMBOL);

  always_comb begin
    up_beat[0]      = '0;
    up_beat[0].sym  = symbol_i;
    up_beat[0].last = lane_end;
    up_beat[0].dir  = dir_q;
    up_beat[0].fill = fill_q;
    up_beat[0].vc   = vc_q;
    up_beat[0].dfwd = dfwd_q;
    up_beat[0].base = base_q;
  end

  // Cell 0 -> 1: lane delay in vectors.
  always_comb begin
    up_beat[1]     = dn_beat[0];
    up_beat[1].dly = (dn_beat[0].dir == DIR_REV) ?
                     SLOT_W'(SPAN - 1) - dn_beat[0].dfwd : dn_beat[0].dfwd;
  end

  // Cell 1 -> 2: circular read slot; a slot is live only once enough whole
  // vectors have gone by since flush.
  always_comb begin
    up_beat[2]      = dn_beat[1];
    up_beat[2].slot = (dn_beat[1].vc >= dn_beat[1].dly) ?
                      dn_beat[1].vc - dn_beat[1].dly :
                      dn_beat[1].vc + SLOT_W'(SPAN) - dn_beat[1].dly;
    up_beat[2].hit  = (dn_beat[1].fill >= dn_beat[1].dly);
    up_beat[2].pass = (dn_beat[1].dly == '0);
  end

  // Cell 2 -> 3: flat RAM addresses.
  always_comb begin
    up_beat[3]         = dn_beat[2];
    up_beat[3].wr_addr = dn_beat[2].base + ADDR_W'(dn_beat[2].vc);
    up_beat[3].rd_addr = dn_beat[2].base + ADDR_W'(dn_beat[2].slot);
  end

  // ---------------------------------------------------------------------------
  // History RAM: written and read as the beat moves from cell 3 to cell 4,
  // so the RAM output register lines up with cell 4 and holds while it stalls.
  // Zero-delay lanes read their own write: bypassed below.
  // ---------------------------------------------------------------------------
  logic             ram_go;
  logic [SYM_W-1:0] ram_rdata;

  assign ram_go     = dn_valid[3] && up_ready[4];
  assign up_beat[4] = dn_beat[3];

  dsi_ram #(
    .WIDTH (SYM_W),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_go),
    .waddr_i (dn_beat[3].wr_addr),
    .wdata_i (dn_beat[3].sym),
    .re_i    (ram_go),
    .raddr_i (dn_beat[3].rd_addr),
    .rdata_o (ram_rdata)
  );

  // Cell 4 -> 5: pick the result symbol.
  always_comb begin
    up_beat[5] = dn_beat[4];
    if (dn_beat[4].pass) begin
      up_beat[5].sym = dn_beat[4].sym;
    end else if (dn_beat[4].hit) begin
      up_beat[5].sym = ram_rdata;
    end else begin
      up_beat[5].sym = '0;
    end
  end

  // Output beat straight from the last cell.
  assign valid_o          = dn_valid[NCELL-1];
  assign symbol_out_o     = dn_beat[NCELL-1].sym;
  assign last_of_vector_o = dn_beat[NCELL-1].last;

endmodule

`default_nettype wire

/* dv/tb_diagonal_symbol_interleaver.sv */
`timescale 1ns / 1ps

module tb_diagonal_symbol_interleaver;
  import dsi_pkg::*;

  localparam int CLK_HALF    = 2;       // 4 ns period
  localparam int RST_CYCLES  = 9;
  localparam int LATENCY     = NCELL;   // cells in the block's chain
  localparam int RAND_PHASES = 4;
  localparam int PHASE_BEATS = 357;     // random beats per direction setting
  localparam int DRAIN_LIMIT = 20000;   // cycles allowed for the last results

  // One delayed symbol as the output should carry it.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } lane_out_t;

  // Keeps a byte-wide copy of every lane's delay line and the queue of
  // symbols the block still owes on its output.
  class lane_delay_scoreboard;
    byte unsigned history[];
    int unsigned  lane_idx;
    int unsigned  vec_slot;
    logic         dir;
    lane_out_t    due_q[$];
    int           errors;
    int           results;
    int           flushes;

    function new();
      history  = new[DEPTH];
      lane_idx = 0;
      vec_slot = 0;
      dir      = DIR_FWD;
      errors   = 0;
      results  = 0;
      flushes  = 0;
    endfunction

    function void set_direction(logic d);
      dir = d;
    endfunction

    // Accepted beat: flush clears; symbol writes lane row, reads delayed slot.
    function void note_beat(logic kind, logic [SYM_W-1:0] sym);
      int unsigned base;
      int unsigned dly;
      int unsigned rd_slot;
      lane_out_t   owed;
      if (kind == KIND_FLUSH) begin
        history  = new[DEPTH];  // fresh array reads all zero
        lane_idx = 0;
        vec_slot = 0;
        flushes++;
        return;
      end
      base = lane_idx * SPAN;
      history[base + vec_slot] = sym;
      dly = (dir == DIR_REV) ? STAGES * (LANES - 1 - lane_idx) : STAGES * lane_idx;
      rd_slot   = (vec_slot + SPAN - dly) % SPAN;
      owed.sym  = history[base + rd_slot];
      owed.last = (lane_idx == LANES - 1);
      due_q.push_back(owed);
      if (lane_idx == LANES - 1) begin
        lane_idx = 0;
        vec_slot = (vec_slot + 1) % SPAN;
      end else begin
        lane_idx++;
      end
    endfunction

    function void check_beat(logic [SYM_W-1:0] sym, logic last);
      lane_out_t owed;
      if (due_q.size() == 0) begin
        $error("unexpected result beat: symbol_out=%02h last_of_vector=%0b", sym, last);
        errors++;
        return;
      end
      owed = due_q.pop_front();
      results++;
      if (sym !== owed.sym) begin
        $error("symbol_out: expected %02h, actual %02h", owed.sym, sym);
        errors++;
      end
      if (last !== owed.last) begin
        $error("last_of_vector: expected %0b, actual %0b", owed.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void report_leftover();
      foreach (due_q[i]) begin
        $error("missing result: symbol_out %02h last_of_vector %0b never came",
               due_q[i].sym, due_q[i].last);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             valid_i     = 1'b0;
  logic             stall_o;
  logic             kind_i      = KIND_SYMBOL;
  logic [SYM_W-1:0] symbol_i    = '0;
  logic             valid_o;
  logic             stall_i     = 1'b0;
  logic [SYM_W-1:0] symbol_out_o;
  logic             last_of_vector_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_data_i  = DIR_FWD;

  diagonal_symbol_interleaver dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .stall_o          (stall_o),
    .kind_i           (kind_i),
    .symbol_i         (symbol_i),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .symbol_out_o     (symbol_out_o),
    .last_of_vector_o (last_of_vector_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  lane_delay_scoreboard sb = new();

  int beats_in   = 0;
  int cfg_writes = 0;
  bit quiet_tx   = 1'b0;  // sender in a no-gap stretch
  bit quiet_rx   = 1'b0;  // receiver in a no-stall stretch

  initial begin : clk_gen
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Idle draw per beat, in cycles. Now and then a side flips into or out of
  // a stretch with no idling at all, so back-to-back beats get exercised too.
  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 47) == 0) quiet = ~quiet;
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  // Sender: optional gap, then hold the beat until the block takes it. Valid
  // stays high into the next beat when no gap is drawn.
  task automatic push_beat(input logic kind, input logic [SYM_W-1:0] sym);
    int gap;
    gap = draw_wait(quiet_tx);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i  <= 1'b1;
    kind_i   <= kind;
    symbol_i <= sym;
    do @(posedge clk_i); while (stall_o);
    sb.note_beat(kind, sym);
    beats_in++;
  endtask

  // Direction write only with the block idle: all results back, then a margin
  // past that, since a trailing flush beat yields no result to wait on.
  task automatic write_direction(input logic d);
    valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_direction(d);
    cfg_writes++;
  endtask

  // Receiver: stall for a drawn number of cycles, then take exactly one beat.
  initial begin : rx_side
    int hold;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      hold = draw_wait(quiet_rx);
      if (hold > 0) begin
        stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (!valid_o);
    end
  end

  // Output beats land on the scoreboard at the edge they are accepted.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) sb.check_beat(symbol_out_o, last_of_vector_o);
  end

  initial begin : stimulus
    int   wait_cycles;
    logic kind;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Forward mode: lane 0 passes straight through, every other lane is
    // still empty and must read zero.
    write_direction(DIR_FWD);
    push_beat(KIND_FLUSH, 8'hA5);   // symbol on a flush is ignored
    push_beat(KIND_SYMBOL, 8'h00);
    push_beat(KIND_SYMBOL, 8'hFF);
    push_beat(KIND_SYMBOL, 8'h80);
    push_beat(KIND_SYMBOL, 8'h01);
    push_beat(KIND_SYMBOL, 8'h55);
    push_beat(KIND_SYMBOL, 8'hAA);
    push_beat(KIND_SYMBOL, 8'h7F);
    push_beat(KIND_SYMBOL, 8'hFE);
    push_beat(KIND_FLUSH, 8'h00);   // mid-vector flush, lane count restarts
    push_beat(KIND_SYMBOL, 8'hC3);
    push_beat(KIND_SYMBOL, 8'h3C);
    push_beat(KIND_SYMBOL, 8'hFF);

    // Switch to reverse with history kept: new delays apply at once.
    write_direction(DIR_REV);
    push_beat(KIND_SYMBOL, 8'h00);
    push_beat(KIND_SYMBOL, 8'hFF);
    push_beat(KIND_SYMBOL, 8'h5A);
    push_beat(KIND_SYMBOL, 8'hA5);
    push_beat(KIND_FLUSH, 8'hFF);
    push_beat(KIND_SYMBOL, 8'h12);
    push_beat(KIND_SYMBOL, 8'hED);

    // Random phases, direction alternating without a flush in between. Flush
    // beats are rare so full vectors build up and the last lane shows often.
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_direction((p % 2 == 0) ? DIR_FWD : DIR_REV);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        kind = ($urandom_range(0, 255) == 0) ? KIND_FLUSH : KIND_SYMBOL;
        push_beat(kind, SYM_W'($urandom_range(0, 255)));
      end
    end

    // Drain: wait out every owed result, then a margin for strays.
    valid_i <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (LATENCY * 4) @(posedge clk_i);
    sb.report_leftover();

    $display("Run covered %0d input beats (%0d flushes), %0d results checked,",
             beats_in, sb.flushes, sb.results);
    $display("  %0d direction writes across both settings, mid-stream switches.",
             cfg_writes);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
